// File: src/hbs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the heightmap bilinear sampler.
package hbs_pkg;

	localparam int MAX_COLS     = 64;
	localparam int MAX_ROWS     = 64;
	localparam int HEIGHT_WIDTH = 32;

	localparam int POST_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W     = $clog2(POST_DEPTH);
	localparam int AX_MAX     = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int AX_IDX_W   = $clog2(AX_MAX);
	localparam int AX_CNT_W   = $clog2(AX_MAX + 1);

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X    = 3'd0,
		CFG_ORIGIN_Y    = 3'd1,
		CFG_INV_SPACING = 3'd2,
		CFG_GRID_COLS   = 3'd3,
		CFG_GRID_ROWS   = 3'd4
	} cfg_reg_t;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} adv_t;

	typedef logic signed [HEIGHT_WIDTH-1:0] height_t;

	function automatic logic [ADDR_W-1:0] post_addr(input logic [31:0] row,
		input logic [31:0] col);
		post_addr = ADDR_W'(row * 32'(MAX_COLS) + col);
	endfunction

endpackage

// File: src/hbs_if.sv
`timescale 1ns / 1ps
// Channel interfaces: input items, result words and configuration writes.
interface hbs_item_if import hbs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               action;
	logic [5:0]         post_row;
	logic [5:0]         post_col;
	logic signed [31:0] post_height;
	logic signed [31:0] query_x;
	logic signed [31:0] query_y;

	modport source(output valid, action, post_row, post_col, post_height, query_x, query_y,
		input ready);
	modport sink(input valid, action, post_row, post_col, post_height, query_x, query_y,
		output ready);
endinterface

interface hbs_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sampled_height;
	logic               field_empty;

	modport source(output valid, sampled_height, field_empty, input ready);
	modport sink(input valid, sampled_height, field_empty, output ready);
endinterface

interface hbs_cfg_if import hbs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: src/heightmap_bilinear_sampler_core.sv
`timescale 1ns / 1ps
// Heightmap bilinear sampler, clamp to edge, six-stage pipeline.
// Throughput: one word per cycle unless the result channel stalls.
// The post store is read in one pass by two RAM copies with two read ports each.
// Write words update the post store in stage 3 and produce no result.
// Reset clears the pipeline valids and sets configuration to its defaults;
// the post store is not cleared and holds garbage until written.
module heightmap_bilinear_sampler_core import hbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hbs_item_if.sink    item,
	hbs_result_if.source result,
	hbs_cfg_if.sink     cfg
);

	logic signed [31:0] origin_x_q;
	logic signed [31:0] origin_y_q;
	logic [31:0]        inv_spacing_q;
	logic [6:0]         grid_cols_q;
	logic [6:0]         grid_rows_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= 32'sd0;
			origin_y_q    <= 32'sd0;
			inv_spacing_q <= 32'd65536;
			grid_cols_q   <= 7'd0;
			grid_rows_q   <= 7'd0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_ORIGIN_X:    origin_x_q    <= signed'(cfg.data);
				CFG_ORIGIN_Y:    origin_y_q    <= signed'(cfg.data);
				CFG_INV_SPACING: inv_spacing_q <= cfg.data;
				CFG_GRID_COLS:   grid_cols_q   <= cfg.data[6:0];
				CFG_GRID_ROWS:   grid_rows_q   <= cfg.data[6:0];
				default: begin
				end
			endcase
		end
	end

	// saturate grid size to storage
	logic [AX_CNT_W-1:0] n_x;
	logic [AX_CNT_W-1:0] n_y;
	logic                empty_in;

	assign n_x = (32'(grid_cols_q) > 32'(MAX_COLS)) ? AX_CNT_W'(MAX_COLS)
		: AX_CNT_W'(grid_cols_q);
	assign n_y = (32'(grid_rows_q) > 32'(MAX_ROWS)) ? AX_CNT_W'(MAX_ROWS)
		: AX_CNT_W'(grid_rows_q);
	assign empty_in = (n_x == '0) || (n_y == '0) || (inv_spacing_q == 32'd0);

	// stall chain: a stage loads when it is empty or its successor loads
	adv_t adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	assign adv.s6 = !vld_s6 || result.ready;
	assign adv.s5 = !vld_s5 || adv.s6;
	assign adv.s4 = !vld_s4 || adv.s5;
	assign adv.s3 = !vld_s3 || adv.s4;
	assign adv.s2 = !vld_s2 || adv.s3;
	assign adv.s1 = !vld_s1 || adv.s2;
	assign item.ready = adv.s1;

	logic sample_s1, sample_s2, sample_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv.s1) vld_s1 <= item.valid;
			if (adv.s2) vld_s2 <= vld_s1;
			if (adv.s3) vld_s3 <= vld_s2;
			// drop write words once they reach the store
			if (adv.s4) vld_s4 <= vld_s3 && sample_s3;
			if (adv.s5) vld_s5 <= vld_s4;
			if (adv.s6) vld_s6 <= vld_s5;
		end
	end

	logic        inrange_s1, inrange_s2, inrange_s3;
	logic        empty_s1, empty_s2, empty_s3, empty_s4;
	logic [5:0]  row_s1, row_s2, row_s3;
	logic [5:0]  col_s1, col_s2, col_s3;
	height_t     hgt_s1, hgt_s2, hgt_s3;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			sample_s1  <= (item.action == ACT_SAMPLE);
			inrange_s1 <= (32'(item.post_row) < 32'(MAX_ROWS))
				&& (32'(item.post_col) < 32'(MAX_COLS));
			empty_s1   <= empty_in;
			row_s1     <= item.post_row;
			col_s1     <= item.post_col;
			hgt_s1     <= HEIGHT_WIDTH'(item.post_height);
		end
		if (adv.s2) begin
			sample_s2  <= sample_s1;
			inrange_s2 <= inrange_s1;
			empty_s2   <= empty_s1;
			row_s2     <= row_s1;
			col_s2     <= col_s1;
			hgt_s2     <= hgt_s1;
		end
		if (adv.s3) begin
			sample_s3  <= sample_s2;
			inrange_s3 <= inrange_s2;
			empty_s3   <= empty_s2;
			row_s3     <= row_s2;
			col_s3     <= col_s2;
			hgt_s3     <= hgt_s2;
		end
	end

	logic [AX_IDX_W-1:0] c0_s3, c1_s3, r0_s3, r1_s3;
	logic [15:0]         tx_s3, ty_s3;

	hbs_axis u_axis_x (
		.clk   (clk),
		.adv   (adv),
		.p     (item.query_x),
		.org   (origin_x_q),
		.inv   (inv_spacing_q),
		.n     (n_x),
		.i0_s3 (c0_s3),
		.i1_s3 (c1_s3),
		.t_s3  (tx_s3)
	);

	hbs_axis u_axis_y (
		.clk   (clk),
		.adv   (adv),
		.p     (item.query_y),
		.org   (origin_y_q),
		.inv   (inv_spacing_q),
		.n     (n_y),
		.i0_s3 (r0_s3),
		.i1_s3 (r1_s3),
		.t_s3  (ty_s3)
	);

	logic [15:0] tx_s4, ty_s4;

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			tx_s4    <= tx_s3;
			ty_s4    <= ty_s3;
			empty_s4 <= empty_s3;
		end
	end

	// both copies take every write; each serves one row of the neighborhood
	logic              post_we;
	logic [ADDR_W-1:0] post_waddr;
	height_t           z00, z10, z01, z11;

	assign post_we    = adv.s4 && vld_s3 && !sample_s3 && inrange_s3;
	assign post_waddr = post_addr(32'(row_s3), 32'(col_s3));

	hbs_ram #(
		.WIDTH (HEIGHT_WIDTH),
		.DEPTH (POST_DEPTH)
	) u_ram_lo (
		.clk     (clk),
		.we      (post_we),
		.waddr   (post_waddr),
		.wdata   (hgt_s3),
		.re      (adv.s4),
		.raddr_a (post_addr(32'(r0_s3), 32'(c0_s3))),
		.raddr_b (post_addr(32'(r0_s3), 32'(c1_s3))),
		.rdata_a (z00),
		.rdata_b (z10)
	);

	hbs_ram #(
		.WIDTH (HEIGHT_WIDTH),
		.DEPTH (POST_DEPTH)
	) u_ram_hi (
		.clk     (clk),
		.we      (post_we),
		.waddr   (post_waddr),
		.wdata   (hgt_s3),
		.re      (adv.s4),
		.raddr_a (post_addr(32'(r1_s3), 32'(c0_s3))),
		.raddr_b (post_addr(32'(r1_s3), 32'(c1_s3))),
		.rdata_a (z01),
		.rdata_b (z11)
	);

	logic signed [31:0] height_s6;
	logic               empty_s6;

	hbs_blend u_blend (
		.clk       (clk),
		.adv       (adv),
		.z00       (z00),
		.z10       (z10),
		.z01       (z01),
		.z11       (z11),
		.tx_s4     (tx_s4),
		.ty_s4     (ty_s4),
		.empty_s4  (empty_s4),
		.height_s6 (height_s6),
		.empty_s6  (empty_s6)
	);

	assign result.valid          = vld_s6;
	assign result.sampled_height = height_s6;
	assign result.field_empty    = empty_s6;

endmodule

// File: src/hbs_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports with read enable.
module hbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: src/hbs_axis.sv
`timescale 1ns / 1ps
// One axis of the coordinate map: offset, scale by reciprocal, clamp, split.
module hbs_axis import hbs_pkg::*; (
	input  logic                 clk,
	input  adv_t                 adv,
	input  logic signed [31:0]   p,
	input  logic signed [31:0]   org,
	input  logic [31:0]          inv,
	input  logic [AX_CNT_W-1:0]  n,
	output logic [AX_IDX_W-1:0]  i0_s3,
	output logic [AX_IDX_W-1:0]  i1_s3,
	output logic [15:0]          t_s3
);

	logic signed [32:0] d;
	logic [31:0]        d_s1;
	logic [63:0]        prod;
	logic [47:0]        g_s2;
	logic [47:0]        top;
	logic [47:0]        gc;
	logic [AX_IDX_W-1:0] i0;
	logic [AX_IDX_W-1:0] i1;

	// points at or below the origin land on index zero
	assign d = 33'(p) - 33'(org);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			d_s1 <= (d > 33'sd0) ? d[31:0] : 32'd0;
		end
	end

	assign prod = 64'(d_s1) * 64'(inv);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			g_s2 <= prod[63:16];
		end
	end

	assign top = 48'(32'(n) - 32'd1) << 16;
	assign gc  = (g_s2 > top) ? top : g_s2;
	assign i0  = gc[16 +: AX_IDX_W];
	assign i1  = ((32'(i0) + 32'd1) < 32'(n)) ? AX_IDX_W'(32'(i0) + 32'd1)
		: AX_IDX_W'(32'(n) - 32'd1);

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			i0_s3 <= i0;
			i1_s3 <= i1;
			t_s3  <= gc[15:0];
		end
	end

endmodule

// File: src/hbs_blend.sv
`timescale 1ns / 1ps
// Bilinear blend: x lerp on both rows, then y lerp, rounding and saturation.
module hbs_blend import hbs_pkg::*; (
	input  logic               clk,
	input  adv_t               adv,
	input  height_t            z00,
	input  height_t            z10,
	input  height_t            z01,
	input  height_t            z11,
	input  logic [15:0]        tx_s4,
	input  logic [15:0]        ty_s4,
	input  logic               empty_s4,
	output logic signed [31:0] height_s6,
	output logic               empty_s6
);

	localparam int SW = HEIGHT_WIDTH + 19;

	function automatic height_t lerp(input height_t a, input height_t b,
		input logic [15:0] t);
		logic signed [17:0]   wa;
		logic signed [17:0]   wb;
		logic signed [SW-1:0] sum;
		wa  = signed'({1'b0, 17'(32'd65536 - 32'(t))});
		wb  = signed'({2'b00, t});
		sum = SW'(a) * SW'(wa) + SW'(b) * SW'(wb) + SW'(32768);
		lerp = HEIGHT_WIDTH'(sum >>> 16);
	endfunction

	height_t            low_s5;
	height_t            high_s5;
	logic [15:0]        ty_s5;
	logic               empty_s5;
	height_t            res;
	logic signed [63:0] res_w;
	logic signed [31:0] res_sat;

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			low_s5   <= lerp(z00, z10, tx_s4);
			high_s5  <= lerp(z01, z11, tx_s4);
			ty_s5    <= ty_s4;
			empty_s5 <= empty_s4;
		end
	end

	assign res   = lerp(low_s5, high_s5, ty_s5);
	assign res_w = 64'(res);

	always_comb begin
		priority if (res_w > 64'sd2147483647) begin
			res_sat = 32'sh7fffffff;
		end else if (res_w < -64'sd2147483648) begin
			res_sat = 32'sh80000000;
		end else begin
			res_sat = 32'(res_w);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			height_s6 <= empty_s5 ? 32'sd0 : res_sat;
			empty_s6  <= empty_s5;
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the heightmap bilinear sampler core.
module testbench import hbs_pkg::*; ();

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic signed [31:0] height;
		logic               empty;
	} sample_t;

	localparam int    SETTLE_CYCLES = 12;
	localparam int    STALL_LIMIT   = 4000;
	localparam longint Q_MAX        = 64'sd2147483647;
	localparam longint Q_MIN        = -64'sd2147483648;

	localparam logic signed [31:0] H_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] H_MIN = 32'sh80000000;
	localparam logic signed [31:0] HALF  = 32'sd32768;

	logic clk;
	logic arst_n;

	hbs_item_if   item_ch ();
	hbs_result_if res_ch ();
	hbs_cfg_if    cfg_ch ();

	heightmap_bilinear_sampler_core DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(res_ch),
		.cfg   (cfg_ch)
	);

	// shadow copy of the block: configuration and post store
	logic signed [31:0] cur_org_x;
	logic signed [31:0] cur_org_y;
	logic [31:0]        cur_inv;
	logic [6:0]         cur_cols;
	logic [6:0]         cur_rows;
	height_t            post_mem [POST_DEPTH];
	bit                 post_set [POST_DEPTH];

	sample_t pending_samples [$];
	int      fault_count = 0;
	int      burst_left  = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int eff_cols();
		return (int'(cur_cols) > MAX_COLS) ? MAX_COLS : int'(cur_cols);
	endfunction

	function automatic int eff_rows();
		return (int'(cur_rows) > MAX_ROWS) ? MAX_ROWS : int'(cur_rows);
	endfunction

	function automatic bit field_ready();
		return eff_cols() != 0 && eff_rows() != 0 && cur_inv != 32'd0;
	endfunction

	// clamped Q.16 grid coordinate along one axis
	function automatic u64_t axis_coord(input logic signed [31:0] p,
		input logic signed [31:0] org, input int n);
		longint d;
		u64_t   g;
		u64_t   top;
		d = longint'(p) - longint'(org);
		if (d <= 0)
			return 0;
		g = (u64_t'(d) * u64_t'(cur_inv)) >> 16;
		top = u64_t'(n - 1) << 16;
		return (g > top) ? top : g;
	endfunction

	function automatic void locate(input logic signed [31:0] qx, qy,
		output int c0, c1, r0, r1, tx, ty);
		u64_t gx;
		u64_t gy;
		gx = axis_coord(qx, cur_org_x, eff_cols());
		gy = axis_coord(qy, cur_org_y, eff_rows());
		c0 = int'(gx >> 16);
		r0 = int'(gy >> 16);
		tx = int'(gx[15:0]);
		ty = int'(gy[15:0]);
		c1 = (c0 + 1 < eff_cols()) ? c0 + 1 : eff_cols() - 1;
		r1 = (r0 + 1 < eff_rows()) ? r0 + 1 : eff_rows() - 1;
	endfunction

	function automatic longint post_at(input int r, input int c);
		return longint'(post_mem[r * MAX_COLS + c]);
	endfunction

	// weighted blend, rounded half up by a floor shift
	function automatic longint lerp16(input longint a, input longint b, input int t);
		longint s;
		s = a * longint'(65536 - t) + b * longint'(t);
		return (s + 32768) >>> 16;
	endfunction

	function automatic sample_t predict_sample(input logic signed [31:0] qx, qy);
		sample_t s;
		int      c0, c1, r0, r1, tx, ty;
		longint  lo, hi, v;
		if (!field_ready()) begin
			s.height = '0;
			s.empty = 1'b1;
			return s;
		end
		locate(qx, qy, c0, c1, r0, r1, tx, ty);
		lo = lerp16(post_at(r0, c0), post_at(r0, c1), tx);
		hi = lerp16(post_at(r1, c0), post_at(r1, c1), tx);
		v = lerp16(lo, hi, ty);
		if (v > Q_MAX)
			v = Q_MAX;
		if (v < Q_MIN)
			v = Q_MIN;
		s.height = v[31:0];
		s.empty = 1'b0;
		return s;
	endfunction

	task automatic flag_fault(input string what, input longint want, input longint got);
		$display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
		fault_count++;
	endtask

	task automatic send_word(input logic act, input logic [5:0] row, col,
		input logic signed [31:0] h, qx, qy);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(64, 256);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 6);
			end
			if (gap != 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item_ch.valid       <= 1'b1;
		item_ch.action      <= act;
		item_ch.post_row    <= row;
		item_ch.post_col    <= col;
		item_ch.post_height <= h;
		item_ch.query_x     <= qx;
		item_ch.query_y     <= qy;
		do @(posedge clk); while (!item_ch.ready);
		burst_left--;
		if (act == ACT_WRITE) begin
			post_mem[int'(row) * MAX_COLS + int'(col)] = height_t'(h);
			post_set[int'(row) * MAX_COLS + int'(col)] = 1'b1;
		end else begin
			pending_samples = {pending_samples, predict_sample(qx, qy)};
		end
	endtask

	task automatic do_write(input logic [5:0] row, col, input logic signed [31:0] h);
		send_word(ACT_WRITE, row, col, h, $urandom, $urandom);
	endtask

	function automatic logic signed [31:0] pick_height();
		case ($urandom_range(0, 7))
			0: return H_MAX;
			1: return H_MIN;
			2: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic fill_post(input int r, input int c);
		if (!post_set[r * MAX_COLS + c])
			do_write(r[5:0], c[5:0], pick_height());
	endtask

	// write every post the blend will touch that is not yet set, before the sample goes out
	task automatic do_sample(input logic signed [31:0] qx, qy);
		int c0, c1, r0, r1, tx, ty;
		if (field_ready()) begin
			locate(qx, qy, c0, c1, r0, r1, tx, ty);
			fill_post(r0, c0);
			fill_post(r0, c1);
			fill_post(r1, c0);
			fill_post(r1, c1);
		end
		send_word(ACT_SAMPLE, $urandom, $urandom, $urandom, qx, qy);
	endtask

	// drop valid, drain every result, then let trailing writes leave the pipe
	task automatic settle();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_ORIGIN_X:    cur_org_x = val;
			CFG_ORIGIN_Y:    cur_org_y = val;
			CFG_INV_SPACING: cur_inv = val;
			CFG_GRID_COLS:   cur_cols = val[6:0];
			CFG_GRID_ROWS:   cur_rows = val[6:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic signed [31:0] ox, oy, input logic [31:0] inv,
		input logic [6:0] nc, nr);
		settle();
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_INV_SPACING, inv);
		write_reg(CFG_GRID_COLS, 32'(nc));
		write_reg(CFG_GRID_ROWS, 32'(nr));
		cfg_ch.valid <= 1'b0;
	endtask

	// point that mostly lands in or just around the grid
	function automatic logic signed [31:0] pick_coord(input logic signed [31:0] org,
		input int n);
		longint gq;
		longint delta;
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? H_MAX : H_MIN;
			2: gq = longint'($urandom_range(0, n)) * 65536;
			default: gq = longint'($urandom_range(0, (n + 1) * 65536)) - 65536;
		endcase
		if (cur_inv == 32'd0)
			return $urandom;
		delta = (gq <<< 16) / longint'(cur_inv);
		return org + 32'(delta);
	endfunction

	function automatic logic signed [31:0] pick_origin();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? H_MAX : H_MIN;
			1, 2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_inv();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			3: return 32'd1;
			default: return $urandom_range(32'h2000, 32'h8_0000);
		endcase
	endfunction

	function automatic logic [6:0] pick_size();
		case ($urandom_range(0, 11))
			0: return 7'd0;
			1: return $urandom_range(65, 127);
			2: return 7'd64;
			3: return 7'd1;
			default: return $urandom_range(2, 16);
		endcase
	endfunction

	task automatic test_reset_defaults();
		do_sample(32'sd0, 32'sd0);
		do_sample(H_MAX, H_MIN);
	endtask

	task automatic test_empty_field();
		set_config(32'sd0, 32'sd0, 32'd0, 7'd4, 7'd4);
		do_sample(HALF, HALF);
		set_config(32'sd0, 32'sd0, 32'd65536, 7'd0, 7'd4);
		do_sample(HALF, HALF);
		set_config(32'sd0, 32'sd0, 32'd65536, 7'd4, 7'd0);
		do_sample(HALF, HALF);
	endtask

	task automatic test_extreme_heights();
		set_config(32'sd0, 32'sd0, 32'd65536, 7'd2, 7'd2);
		do_write(6'd0, 6'd0, H_MAX);
		do_write(6'd0, 6'd1, H_MIN);
		do_write(6'd1, 6'd0, H_MIN);
		do_write(6'd1, 6'd1, H_MAX);
		do_sample(32'sd0, 32'sd0);
		do_sample(HALF, 32'sd0);
		do_sample(HALF, HALF);
		do_sample(H_MAX, H_MIN);
		do_sample(H_MIN, H_MAX);
	endtask

	// grid sizes past the store and extreme spacing, clamped on every edge
	task automatic test_oversized_grid();
		set_config(H_MIN, H_MAX, 32'hFFFF_FFFF, 7'd127, 7'd1);
		do_sample(H_MAX, H_MIN);
		do_sample(H_MIN, H_MAX);
		set_config(H_MAX, H_MIN, 32'd1, 7'd1, 7'd127);
		do_sample(H_MIN, H_MAX);
		do_sample(H_MAX, H_MIN);
	endtask

	task automatic test_random_traffic();
		logic [5:0] row, col;
		repeat (10) begin
			set_config(pick_origin(), pick_origin(), pick_inv(), pick_size(), pick_size());
			repeat (200) begin
				if ($urandom_range(0, 199) == 0) begin
					// hold off until the pipe has handed back every result
					item_ch.valid <= 1'b0;
					burst_left = 0;
					do @(posedge clk); while (pending_samples.size() != 0);
				end
				if ($urandom_range(0, 3) == 0) begin
					row = $urandom;
					col = $urandom;
					if (field_ready() && $urandom_range(0, 1) == 1) begin
						row = $urandom_range(0, eff_rows() - 1);
						col = $urandom_range(0, eff_cols() - 1);
					end
					do_write(row, col, pick_height());
				end else begin
					do_sample(pick_coord(cur_org_x, eff_cols()),
						pick_coord(cur_org_y, eff_rows()));
				end
			end
		end
	endtask

	// result receiver: the stall pattern switches between always ready, random ready and stall bursts
	initial begin
		int mode;
		int mode_left;
		int stall_left;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(32, 256);
			end else begin
				mode_left--;
			end
			case (mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= $urandom_range(0, 1);
				default: begin
					if (stall_left != 0) begin
						stall_left--;
						res_ch.ready <= 1'b0;
					end else begin
						res_ch.ready <= 1'b1;
						if ($urandom_range(0, 3) == 0)
							stall_left = $urandom_range(1, 8);
					end
				end
			endcase
		end
	end

	initial begin
		sample_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (pending_samples.size() == 0) begin
					flag_fault("result word with no sample pending", 0,
						longint'(res_ch.sampled_height));
				end else begin
					want = pending_samples.pop_front();
					if (res_ch.sampled_height !== want.height)
						flag_fault("sampled_height", longint'(want.height),
							longint'(res_ch.sampled_height));
					if (res_ch.field_empty !== want.empty)
						flag_fault("field_empty", longint'(want.empty),
							longint'(res_ch.field_empty));
				end
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("heightmap_bilinear_sampler_core: mismatch");
		$finish;
	end

	initial begin
		arst_n              <= 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.action      <= ACT_WRITE;
		item_ch.post_row    <= '0;
		item_ch.post_col    <= '0;
		item_ch.post_height <= '0;
		item_ch.query_x     <= '0;
		item_ch.query_y     <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= CFG_ORIGIN_X;
		cfg_ch.data         <= '0;
		cur_org_x = '0;
		cur_org_y = '0;
		cur_inv   = 32'd65536;
		cur_cols  = '0;
		cur_rows  = '0;
		foreach (post_set[i]) begin
			post_set[i] = 1'b0;
			post_mem[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_empty_field();
		test_extreme_heights();
		test_oversized_grid();
		test_random_traffic();

		settle();
		if (fault_count == 0)
			$display("heightmap_bilinear_sampler_core: match");
		else
			$display("heightmap_bilinear_sampler_core: mismatch");
		$finish;
	end

endmodule

// File: heightmap_bilinear_sampler_core.f
src/hbs_pkg.sv
src/hbs_if.sv
src/hbs_ram.sv
src/hbs_axis.sv
src/hbs_blend.sv
src/heightmap_bilinear_sampler_core.sv
test/testbench.sv
